>>> hdl/dbba_pkg.sv
// Shared constants, codes and types of the disk block bitmap allocator.
// No dependencies; every other file imports this package.
package dbba_pkg;

    localparam int HEAD_COUNT_DEF     = 4;
    localparam int CYLINDER_COUNT_DEF = 32;
    localparam int SECTOR_COUNT_DEF   = 8;
    localparam int MAX_ALLOC_DEF      = 64;

    localparam int WORD_W  = 32;
    localparam int WORD_SH = 5;
    localparam int LIN_W   = 13;
    localparam int FREE_W  = 14;
    localparam int REM_W   = 7;
    localparam int CNT_W   = 7;
    localparam int CYL_W   = 6;
    localparam int HEAD_W  = 3;
    localparam int SEC_W   = 4;
    localparam int RCP_SH  = 20;
    localparam int PROD1_W = LIN_W + RCP_SH + 1;
    localparam int PROD2_W = REM_W + RCP_SH + 1;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_ALLOC    = 3'd0,
        ST_NOSPACE  = 3'd1,
        ST_RELEASED = 3'd2,
        ST_INVALID  = 3'd3,
        ST_ZERO     = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_PICK,
        S_CV1,
        S_CV2,
        S_CV3,
        S_CV4,
        S_REL,
        S_EMIT
    } t_state;

endpackage

>>> hdl/dbba_req_if.sv
// Request channel of the allocator: valid/ready handshake and request word.
// Depends on dbba_pkg.
interface dbba_req_if import dbba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              op;
    logic [CNT_W-1:0]  count;
    logic [CYL_W-1:0]  cylinder;
    logic [HEAD_W-1:0] head;
    logic [SEC_W-1:0]  sector;

    modport source (output valid, op, count, cylinder, head, sector, input ready);
    modport sink   (input valid, op, count, cylinder, head, sector, output ready);
endinterface

>>> hdl/dbba_res_if.sv
// Result channel of the allocator: valid/ready handshake and result word.
// Depends on dbba_pkg.
interface dbba_res_if import dbba_pkg::*; ();
    logic              valid;
    logic              ready;
    t_status           status;
    logic [CYL_W-1:0]  out_cylinder;
    logic [HEAD_W-1:0] out_head;
    logic [SEC_W-1:0]  out_sector;
    logic              last;

    modport source (output valid, status, out_cylinder, out_head, out_sector, last,
                    input ready);
    modport sink   (input valid, status, out_cylinder, out_head, out_sector, last,
                    output ready);
endinterface

>>> hdl/disk_block_bitmap_allocator_core.sv
// Channel   Dir  Modport  Word
// i_req     in   sink     op, count, cylinder, head, sector
// o_res     out  source   status, out_cylinder, out_head, out_sector, last
//
// Bitmap held in 32-bit words of one synchronous RAM, with a valid flag per word
// cleared at reset, so no clearing pass is needed. Release in range: read, load,
// check, emit. Allocate: set-up, then a load and a pick per fully used word
// scanned, and per block granted the read-modify-write of a word and the
// reciprocal-multiply address unit. Zero, no-space and out-of-range release
// requests go straight to emit. One request at a time; i_req.ready is high only
// when idle. A stalled result holds in the output register. Reset (synchronous,
// active low) frees every block.
// Depends on dbba_pkg, dbba_req_if and dbba_res_if.
module disk_block_bitmap_allocator_core import dbba_pkg::*; #(
    parameter int HEAD_COUNT     = HEAD_COUNT_DEF,
    parameter int CYLINDER_COUNT = CYLINDER_COUNT_DEF,
    parameter int SECTOR_COUNT   = SECTOR_COUNT_DEF,
    parameter int MAX_ALLOC      = MAX_ALLOC_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    dbba_req_if.sink   i_req,
    dbba_res_if.source o_res
);

    localparam int PER_CYL   = HEAD_COUNT * SECTOR_COUNT;
    localparam int TOTAL     = CYLINDER_COUNT * PER_CYL;
    localparam int WORDS     = (TOTAL + WORD_W - 1) / WORD_W;
    localparam int WA_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LAST_BITS = TOTAL - (WORDS - 1) * WORD_W;
    localparam int RCP_CYL   = ((1 << RCP_SH) + PER_CYL - 1) / PER_CYL;
    localparam int RCP_SEC   = ((1 << RCP_SH) + SECTOR_COUNT - 1) / SECTOR_COUNT;
    localparam logic [WORD_W-1:0] LAST_MASK = {WORD_W{1'b1}} >> (WORD_W - LAST_BITS);

    logic [WORD_W-1:0] r_mem [WORDS];
    logic              r_vld [WORDS];
    logic [WORD_W-1:0] r_rdata;
    logic              r_rvld;

    t_state            r_state, n_state;
    logic [FREE_W-1:0] r_free, n_free;
    logic              r_ov, n_ov;
    logic              r_op, n_op;
    logic [WA_W-1:0]   r_wa, n_wa;
    logic [WORD_W-1:0] r_word, n_word;
    logic [LIN_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_need, n_need;
    logic [CYL_W-1:0]  r_cyl, n_cyl;
    logic [HEAD_W-1:0] r_head, n_head;
    logic [SEC_W-1:0]  r_sec, n_sec;
    logic [REM_W-1:0]  r_rem, n_rem;
    t_status           r_status, n_status;
    logic              r_last, n_last;
    t_status           r_ostatus, n_ostatus;
    logic [CYL_W-1:0]  r_ocyl, n_ocyl;
    logic [HEAD_W-1:0] r_ohead, n_ohead;
    logic [SEC_W-1:0]  r_osec, n_osec;
    logic              r_olast, n_olast;

    logic              rd_en, wr_en;
    logic [WA_W-1:0]   rd_addr;
    logic [WORD_W-1:0] wr_data;
    logic              out_ok;
    logic [LIN_W-1:0]  rel_idx;
    logic              rel_ok;
    logic              no_space;
    logic [WORD_W-1:0] word_mask, free_bits, iso;
    logic              found;
    logic [WORD_SH-1:0] bitpos;
    logic [PROD1_W-1:0] prod1;
    logic [PROD2_W-1:0] prod2;
    logic [LIN_W-1:0]  rem_full;
    logic [REM_W-1:0]  sec_full;

    assign out_ok   = !r_ov || o_res.ready;
    assign rel_idx  = LIN_W'(i_req.cylinder) * LIN_W'(PER_CYL)
                    + LIN_W'(i_req.head) * LIN_W'(SECTOR_COUNT) + LIN_W'(i_req.sector);
    assign rel_ok   = {1'b0, rel_idx} < (LIN_W + 1)'(TOTAL);
    assign no_space = (i_req.count > CNT_W'(MAX_ALLOC)) || (FREE_W'(i_req.count) > r_free);

    assign word_mask = (r_wa == WA_W'(WORDS - 1)) ? LAST_MASK : {WORD_W{1'b1}};
    assign free_bits = ~r_word & word_mask;
    assign iso       = free_bits & (~free_bits + WORD_W'(1));
    assign found     = |free_bits;

    always_comb begin
        bitpos = '0;
        for (int j = 0; j < WORD_W; j++) begin
            bitpos = bitpos | (iso[j] ? WORD_SH'(j) : '0);
        end
    end

    assign prod1    = PROD1_W'(r_idx) * PROD1_W'(RCP_CYL);
    assign prod2    = PROD2_W'(r_rem) * PROD2_W'(RCP_SEC);
    assign rem_full = r_idx - LIN_W'(LIN_W'(r_cyl) * LIN_W'(PER_CYL));
    assign sec_full = r_rem - REM_W'(REM_W'(r_head) * REM_W'(SECTOR_COUNT));

    always_comb begin
        n_state   = r_state;
        n_free    = r_free;
        n_ov      = r_ov && !o_res.ready;
        n_op      = r_op;
        n_wa      = r_wa;
        n_word    = r_word;
        n_idx     = r_idx;
        n_need    = r_need;
        n_cyl     = r_cyl;
        n_head    = r_head;
        n_sec     = r_sec;
        n_rem     = r_rem;
        n_status  = r_status;
        n_last    = r_last;
        n_ostatus = r_ostatus;
        n_ocyl    = r_ocyl;
        n_ohead   = r_ohead;
        n_osec    = r_osec;
        n_olast   = r_olast;
        rd_en     = 1'b0;
        rd_addr   = r_wa;
        wr_en     = 1'b0;
        wr_data   = r_word;
        i_req.ready = 1'b0;

        case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_op   = i_req.op;
                    n_last = 1'b1;
                    n_need = '0;
                    if (i_req.op == OP_RELEASE) begin
                        n_cyl  = i_req.cylinder;
                        n_head = i_req.head;
                        n_sec  = i_req.sector;
                        n_idx  = rel_idx;
                        if (rel_ok) begin
                            n_wa    = rel_idx[WORD_SH +: WA_W];
                            rd_en   = 1'b1;
                            rd_addr = rel_idx[WORD_SH +: WA_W];
                            n_state = S_LOAD;
                        end else begin
                            n_status = ST_INVALID;
                            n_state  = S_EMIT;
                        end
                    end else if (i_req.count == '0 || no_space) begin
                        n_status = (i_req.count == '0) ? ST_ZERO : ST_NOSPACE;
                        n_cyl    = '0;
                        n_head   = '0;
                        n_sec    = '0;
                        n_state  = S_EMIT;
                    end else begin
                        n_need  = i_req.count;
                        n_wa    = '0;
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                n_word  = r_rvld ? r_rdata : '0;
                n_state = (r_op == OP_RELEASE) ? S_REL : S_PICK;
            end
            S_PICK: begin
                if (found) begin
                    n_word   = r_word | iso;
                    wr_en    = 1'b1;
                    wr_data  = r_word | iso;
                    n_idx    = LIN_W'({r_wa, bitpos});
                    n_need   = r_need - CNT_W'(1);
                    n_free   = r_free - FREE_W'(1);
                    n_last   = (r_need == CNT_W'(1));
                    n_status = ST_ALLOC;
                    n_state  = S_CV1;
                end else begin
                    n_wa    = r_wa + WA_W'(1);
                    rd_en   = 1'b1;
                    rd_addr = r_wa + WA_W'(1);
                    n_state = S_LOAD;
                end
            end
            S_CV1: begin
                n_cyl   = prod1[RCP_SH +: CYL_W];
                n_state = S_CV2;
            end
            S_CV2: begin
                n_rem   = rem_full[REM_W-1:0];
                n_state = S_CV3;
            end
            S_CV3: begin
                n_head  = prod2[RCP_SH +: HEAD_W];
                n_state = S_CV4;
            end
            S_CV4: begin
                n_sec   = sec_full[SEC_W-1:0];
                n_state = S_EMIT;
            end
            S_REL: begin
                if (r_word[r_idx[WORD_SH-1:0]]) begin
                    wr_en    = 1'b1;
                    wr_data  = r_word & ~(WORD_W'(1) << r_idx[WORD_SH-1:0]);
                    n_free   = r_free + FREE_W'(1);
                    n_status = ST_RELEASED;
                end else begin
                    n_status = ST_INVALID;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_ok) begin
                    n_ov      = 1'b1;
                    n_ostatus = r_status;
                    n_ocyl    = r_cyl;
                    n_ohead   = r_head;
                    n_osec    = r_sec;
                    n_olast   = r_last;
                    n_state   = (r_need != '0) ? S_PICK : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_free  <= FREE_W'(TOTAL);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_wa      <= n_wa;
        r_word    <= n_word;
        r_idx     <= n_idx;
        r_need    <= n_need;
        r_cyl     <= n_cyl;
        r_head    <= n_head;
        r_sec     <= n_sec;
        r_rem     <= n_rem;
        r_status  <= n_status;
        r_last    <= n_last;
        r_ostatus <= n_ostatus;
        r_ocyl    <= n_ocyl;
        r_ohead   <= n_ohead;
        r_osec    <= n_osec;
        r_olast   <= n_olast;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wa] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < WORDS; w++) begin
                r_vld[w] <= 1'b0;
            end
            r_rvld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[r_wa] <= 1'b1;
            end
            if (rd_en) begin
                r_rvld <= r_vld[rd_addr];
            end
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.status       = r_ostatus;
    assign o_res.out_cylinder = r_ocyl;
    assign o_res.out_head     = r_ohead;
    assign o_res.out_sector   = r_osec;
    assign o_res.last         = r_olast;

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= FREE_W'(TOTAL))
        else $error("free count above bitmap size");

    a_pick_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK) |-> (r_need != '0))
        else $error("scan running with nothing left to grant");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK) |-> (r_wa <= WA_W'(WORDS - 1)))
        else $error("scan ran past the bitmap");

    a_pick_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK && found) |=> (r_free == $past(r_free) - FREE_W'(1)))
        else $error("granted block not taken off the free count");

endmodule

>>> dv/disk_block_bitmap_allocator_core_tb.sv
// Self-checking testbench of disk_block_bitmap_allocator_core: directed,
// fill, churn, back-pressure and flat-out tests against a first-fit bitmap
// predictor. Depends on dbba_pkg, dbba_req_if, dbba_res_if and the core.
module disk_block_bitmap_allocator_core_tb import dbba_pkg::*; ;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEADS        = HEAD_COUNT_DEF;
    localparam int CYLS         = CYLINDER_COUNT_DEF;
    localparam int SECTORS      = SECTOR_COUNT_DEF;
    localparam int ALLOC_MAX    = MAX_ALLOC_DEF;
    localparam int PER_CYL      = HEADS * SECTORS;
    localparam int DISK_BLOCKS  = CYLS * PER_CYL;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_LONG    = 300;

    typedef struct packed {
        t_status           status;
        logic [CYL_W-1:0]  cyl;
        logic [HEAD_W-1:0] hd;
        logic [SEC_W-1:0]  sec;
        logic              last;
    } t_blk_res;

    logic clk;
    logic rst_n;

    dbba_req_if req_if ();
    dbba_res_if res_if ();

    disk_block_bitmap_allocator_core #(
        .HEAD_COUNT     (HEADS),
        .CYLINDER_COUNT (CYLS),
        .SECTOR_COUNT   (SECTORS),
        .MAX_ALLOC      (ALLOC_MAX)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    bit       used_map [DISK_BLOCKS];
    int       free_cnt;
    t_blk_res pending_res [$];

    bit idle_on;
    int hold_cycles;
    int err_cnt;
    int words_sent;
    int res_seen;
    int granted_cnt;
    int released_cnt;
    int nospace_cnt;
    int invalid_cnt;
    int zero_cnt;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void push_res(input t_status st, input int lin_cyl, input int lin_hd,
                                     input int lin_sec, input logic lst);
        t_blk_res r;
        r.status = st;
        r.cyl    = CYL_W'(lin_cyl);
        r.hd     = HEAD_W'(lin_hd);
        r.sec    = SEC_W'(lin_sec);
        r.last   = lst;
        pending_res.insert(pending_res.size(), r);
    endfunction

    // First-fit bitmap allocator, one request word at a time
    function automatic void alloc_predict(input logic op, input logic [CNT_W-1:0] cnt,
                                          input logic [CYL_W-1:0] cyl,
                                          input logic [HEAD_W-1:0] hd,
                                          input logic [SEC_W-1:0] sec);
        int lin;
        int n;
        if (op == OP_ALLOC) begin
            if (cnt == 0) begin
                push_res(ST_ZERO, 0, 0, 0, 1'b1);
                zero_cnt++;
            end else if (int'(cnt) > ALLOC_MAX || int'(cnt) > free_cnt) begin
                push_res(ST_NOSPACE, 0, 0, 0, 1'b1);
                nospace_cnt++;
            end else begin
                n = 0;
                for (lin = 0; lin < DISK_BLOCKS && n < int'(cnt); lin++) begin
                    if (!used_map[lin]) begin
                        used_map[lin] = 1'b1;
                        free_cnt--;
                        n++;
                        push_res(ST_ALLOC, lin / PER_CYL, (lin % PER_CYL) / SECTORS,
                                 lin % SECTORS, n == int'(cnt));
                        granted_cnt++;
                    end
                end
            end
        end else begin
            lin = int'(cyl) * PER_CYL + int'(hd) * SECTORS + int'(sec);
            if (lin < DISK_BLOCKS && used_map[lin]) begin
                used_map[lin] = 1'b0;
                free_cnt++;
                push_res(ST_RELEASED, cyl, hd, sec, 1'b1);
                released_cnt++;
            end else begin
                push_res(ST_INVALID, cyl, hd, sec, 1'b1);
                invalid_cnt++;
            end
        end
    endfunction

    task automatic send_word(input logic op, input logic [CNT_W-1:0] cnt,
                             input logic [CYL_W-1:0] cyl, input logic [HEAD_W-1:0] hd,
                             input logic [SEC_W-1:0] sec);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.op       <= op;
        req_if.count    <= cnt;
        req_if.cylinder <= cyl;
        req_if.head     <= hd;
        req_if.sector   <= sec;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        alloc_predict(op, cnt, cyl, hd, sec);
        words_sent++;
    endtask

    task automatic wait_drain();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_res.size() != 0) @(posedge clk);
    endtask

    task automatic send_alloc(input int cnt);
        send_word(OP_ALLOC, CNT_W'(cnt), CYL_W'($urandom), HEAD_W'($urandom),
                  SEC_W'($urandom));
    endtask

    // Pick a used block if there is one, addressed canonically or through an alias
    task automatic send_release_used();
        int start;
        int lin;
        int k;
        logic [CYL_W-1:0]  c;
        logic [HEAD_W-1:0] h;
        logic [SEC_W-1:0]  s;
        start = $urandom_range(0, DISK_BLOCKS - 1);
        lin   = start;
        for (k = 0; k < DISK_BLOCKS; k++) begin
            if (used_map[(start + k) % DISK_BLOCKS]) begin
                lin = (start + k) % DISK_BLOCKS;
                break;
            end
        end
        c = CYL_W'(lin / PER_CYL);
        h = HEAD_W'((lin % PER_CYL) / SECTORS);
        s = SEC_W'(lin % SECTORS);
        case ($urandom_range(0, 3))
            0: if (c > 0) begin
                c = c - 1'b1;
                h = h + HEAD_W'(HEADS);
            end
            1: if (h > 0) begin
                h = h - 1'b1;
                s = s + SEC_W'(SECTORS);
            end
            default: ;
        endcase
        send_word(OP_RELEASE, CNT_W'($urandom), c, h, s);
    endtask

    task automatic test_directed();
        send_word(OP_ALLOC, 7'd0, 6'd0, 3'd0, 4'd0);
        send_word(OP_ALLOC, 7'd1, 6'd0, 3'd0, 4'd0);
        send_word(OP_ALLOC, 7'd64, 6'd0, 3'd0, 4'd0);
        send_word(OP_ALLOC, 7'd65, 6'd0, 3'd0, 4'd0);
        send_word(OP_ALLOC, 7'd127, 6'd63, 3'd7, 4'd15);
        send_word(OP_RELEASE, 7'd0, 6'd0, 3'd0, 4'd0);
        send_word(OP_RELEASE, 7'd0, 6'd0, 3'd0, 4'd0);
        send_word(OP_RELEASE, 7'd0, 6'd0, 3'd5, 4'd0);
        send_word(OP_RELEASE, 7'd0, 6'd0, 3'd0, 4'd9);
        send_word(OP_RELEASE, 7'd0, 6'd63, 3'd7, 4'd15);
        send_word(OP_RELEASE, 7'd0, 6'd32, 3'd0, 4'd0);
        send_word(OP_RELEASE, 7'd0, 6'd31, 3'd7, 4'd15);
        send_word(OP_RELEASE, 7'd0, 6'd20, 3'd2, 4'd3);
        send_word(OP_ALLOC, 7'd3, 6'd0, 3'd0, 4'd0);
        send_word(OP_ALLOC, 7'd2, 6'd0, 3'd0, 4'd0);
        send_word(OP_RELEASE, 7'd0, 6'd31, 3'd3, 4'd7);
        send_word(OP_ALLOC, 7'd0, 6'd63, 3'd7, 4'd15);
        send_word(OP_RELEASE, 7'd127, 6'd2, 3'd0, 4'd1);
        send_word(OP_RELEASE, 7'd127, 6'd2, 3'd0, 4'd1);
    endtask

    // Allocate random runs until the disk is full, probing no-space at the edge
    task automatic test_fill_disk();
        while (free_cnt >= ALLOC_MAX) send_alloc($urandom_range(1, ALLOC_MAX));
        if (free_cnt > 0) begin
            send_alloc(free_cnt + $urandom_range(1, ALLOC_MAX - free_cnt));
            send_alloc(free_cnt);
        end
        send_alloc(1);
        send_alloc(ALLOC_MAX);
    endtask

    task automatic test_churn(input int n_words);
        int k;
        int r;
        int sz;
        for (k = 0; k < n_words; k++) begin
            idle_on = ((k / 30) % 3) != 2;
            r = $urandom_range(0, 99);
            if (r < 45) begin
                send_release_used();
            end else if (r < 80) begin
                sz = $urandom_range(0, 99);
                if (sz < 70)      send_alloc($urandom_range(1, 8));
                else if (sz < 85) send_alloc($urandom_range(9, ALLOC_MAX));
                else if (sz < 95) send_alloc(0);
                else              send_alloc($urandom_range(ALLOC_MAX + 1, 127));
            end else begin
                send_word(OP_RELEASE, CNT_W'($urandom), CYL_W'($urandom), HEAD_W'($urandom),
                          SEC_W'($urandom));
            end
        end
        idle_on = 1'b1;
    endtask

    // Hold the result side while words keep coming, then let everything settle
    task automatic test_backpressure();
        int k;
        hold_cycles = HOLD_LONG;
        for (k = 0; k < 6; k++) begin
            if (k % 2 == 0) send_release_used();
            else            send_alloc($urandom_range(4, 16));
        end
        wait_drain();
    endtask

    task automatic test_flat_out(input int n_words);
        int k;
        idle_on = 1'b0;
        for (k = 0; k < n_words; k++) begin
            if ($urandom_range(0, 2) != 0) send_release_used();
            else                           send_alloc($urandom_range(0, 6));
        end
        wait_drain();
    endtask

    task automatic check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
                     got_v);
        end
    endtask

    initial begin
        res_if.ready <= 1'b0;
        @(posedge rst_n);
        forever begin : res_sink
            int stall_left;
            @(posedge clk);
            if (hold_cycles > 0) begin
                res_if.ready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                res_if.ready <= 1'b0;
                stall_left = $urandom_range(1, 9) - 1;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        t_blk_res exp_r;
        forever begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready) begin
                res_seen++;
                if (pending_res.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result word, expected none, actual status %0d",
                             $time, res_if.status);
                end else begin
                    exp_r = pending_res.pop_front();
                    check_field("status", exp_r.status, res_if.status);
                    check_field("out_cylinder", exp_r.cyl, res_if.out_cylinder);
                    check_field("out_head", exp_r.hd, res_if.out_head);
                    check_field("out_sector", exp_r.sec, res_if.out_sector);
                    check_field("last", exp_r.last, res_if.last);
                end
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
            else quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("%0t: no word moved for %0d cycles, %0d results outstanding", $time,
                         quiet, pending_res.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int k;
        rst_n           <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.op       <= OP_ALLOC;
        req_if.count    <= '0;
        req_if.cylinder <= '0;
        req_if.head     <= '0;
        req_if.sector   <= '0;
        for (k = 0; k < DISK_BLOCKS; k++) used_map[k] = 1'b0;
        free_cnt    = DISK_BLOCKS;
        idle_on     = 1'b1;
        hold_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_disk();
        test_churn(150);
        test_backpressure();
        test_flat_out(60);

        repeat (40) @(posedge clk);
        $display("Sent %0d request words, checked %0d result words", words_sent, res_seen);
        $display("Granted %0d, released %0d, no-space %0d, invalid %0d, zero %0d",
                 granted_cnt, released_cnt, nospace_cnt, invalid_cnt, zero_cnt);
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
